### rtl/assert_macros.svh
// Concurrent check helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define CHK_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### rtl/tbcp_pkg.sv
package tbcp_pkg;

  localparam logic [3:0] FLAG_LEFT  = 4'h1;
  localparam logic [3:0] FLAG_RIGHT = 4'h2;
  localparam logic [3:0] FLAG_UP    = 4'h4;
  localparam logic [3:0] FLAG_DOWN  = 4'h8;

  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // floor(v / 15) = (v * 2185) >> 15 for any 12-bit v
  localparam logic [11:0] RECIP_15   = 12'd2185;
  localparam int          RECIP_SHFT = 15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LAST,
    ST_FIN
  } st_t;

  function automatic logic [3:0] corner_flags(input logic [1:0] idx);
    logic [3:0] f;
    unique case (idx)
      2'd0:    f = FLAG_LEFT | FLAG_UP;
      2'd1:    f = FLAG_RIGHT | FLAG_UP;
      2'd2:    f = FLAG_LEFT | FLAG_DOWN;
      default: f = FLAG_RIGHT | FLAG_DOWN;
    endcase
    return f;
  endfunction

  // q is the low nibble of y/240, ylow the low byte of y
  function automatic logic [7:0] probe_addr(input logic orient, input logic [15:0] xc,
                                            input logic [3:0] q, input logic [7:0] ylow);
    logic [7:0] ry;
    logic       screen;
    ry     = ylow + {q, 4'b0000};
    screen = orient ? xc[8] : q[0];
    return {screen, ry[7], xc[7], ry[6:3], xc[6]};
  endfunction

  function automatic logic [7:0] push_axis(input logic [7:0] lo, input logic [7:0] hi,
                                           input logic hit_lo, input logic hit_hi);
    logic [7:0] span;
    logic [7:0] res;
    span = hi + 8'd1 - lo;
    if (hit_lo && !hit_hi) begin
      res = 8'd8 - {5'b00000, lo[2:0]};
    end else if (hit_hi && !hit_lo) begin
      res = (hi - lo) - {5'b00000, hi[2:0]};
    end else begin
      res = {1'b0, span[7:1]};
    end
    return res;
  endfunction

endpackage

### rtl/tile_box_collision_probe.sv
// Tile box collision probe.
// Request channel: start with operation and the box or bitmap fields; a request is
// taken at a rising edge with start high and busy low.
// A write request (operation 1) stores bitmap_byte at bitmap_address in the
// 256-byte bitmap in the accepting cycle; busy stays low, so one write per cycle.
// A test request (operation 0) probes the four box corners, one bitmap read per
// corner through the single read port of the bitmap memory, after a state ST_DIV
// that divides both y coordinates by 240. busy is high from ST_DIV through ST_FIN,
// so no request is taken mid-test; done is registered from ST_FIN and the result
// shows for one cycle with done high, the first cycle a new request can be taken.
// Results cannot be stalled: collided, side_flags, push_x and push_y are valid
// only while done is high.
// orientation is written through cfg_valid / cfg_ready / cfg_data; the user is to
// write it only while idle, which the block itself does not enforce; cfg_ready is always high.
// Reset clears the sequencer, done and orientation; bitmap contents stay
// undefined until written.
module tile_box_collision_probe
  import tbcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [15:0]       box_left,
  input  logic [15:0]       box_top,
  input  logic [15:0]       box_right,
  input  logic [15:0]       box_bottom,
  input  logic [7:0]        bitmap_address,
  input  logic [7:0]        bitmap_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              done,
  output logic              collided,
  output logic [3:0]        side_flags,
  output logic signed [7:0] push_x,
  output logic signed [7:0] push_y
);

  st_t         state, state_next;
  logic        orientation;
  logic [7:0]  mem [256];
  logic [15:0] x, y, r, b;
  logic [3:0]  q_y, q_b;
  logic [23:0] prod_y, prod_b;
  logic [7:0]  rd_data;
  logic [2:0]  rd_bit;
  logic [1:0]  rd_idx, issue_idx;
  logic        rd_en, sample_en;
  logic [15:0] xc;
  logic [3:0]  qc;
  logic [7:0]  yc, rd_addr;
  logic [3:0]  flags;
  logic        accept;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    sample_en  = 1'b0;
    issue_idx  = 2'd0;
    unique case (state)
      ST_IDLE: begin
        if (accept && operation == OP_TEST) state_next = ST_DIV;
      end
      ST_DIV: state_next = ST_RD0;
      ST_RD0: begin
        rd_en = 1'b1;
        issue_idx = 2'd0;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        rd_en = 1'b1;
        sample_en = 1'b1;
        issue_idx = 2'd1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        rd_en = 1'b1;
        sample_en = 1'b1;
        issue_idx = 2'd2;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        rd_en = 1'b1;
        sample_en = 1'b1;
        issue_idx = 2'd3;
        state_next = ST_LAST;
      end
      ST_LAST: begin
        sample_en = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      orientation <= cfg_data;
    end
  end

  assign prod_y = y[15:4] * RECIP_15;
  assign prod_b = b[15:4] * RECIP_15;

  assign xc      = issue_idx[0] ? r : x;
  assign qc      = issue_idx[1] ? q_b : q_y;
  assign yc      = issue_idx[1] ? b[7:0] : y[7:0];
  assign rd_addr = probe_addr(orientation, xc, qc, yc);

  always_ff @(posedge clk) begin
    if (accept && operation == OP_WRITE) begin
      mem[bitmap_address] <= bitmap_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x <= box_left;
      y <= box_top;
      r <= box_right - 16'd1;
      b <= box_bottom - 16'd1;
      flags <= 4'h0;
    end else if (sample_en && rd_data[rd_bit]) begin
      flags <= flags | corner_flags(rd_idx);
    end
    if (state == ST_DIV) begin
      q_y <= prod_y[RECIP_SHFT +: 4];
      q_b <= prod_b[RECIP_SHFT +: 4];
    end
    if (rd_en) begin
      rd_idx <= issue_idx;
      rd_bit <= xc[5:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      collided   <= (flags != 4'h0);
      side_flags <= flags;
      push_x     <= signed'(push_axis(x[7:0], r[7:0], flags[0], flags[1]));
      push_y     <= signed'(push_axis(y[7:0], b[7:0], flags[2], flags[3]));
    end
  end

endmodule

### rtl/tbcp_checker.sv
`include "assert_macros.svh"

module tbcp_checker
  import tbcp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic done
);

  `CHK_IMPLY(a_done_idle, clk, rst, done, !busy)
  `CHK_NEXT(a_done_pulse, clk, rst, done, !done)
  `CHK_NEXT(a_test_busy, clk, rst, start && !busy && operation == OP_TEST, busy)
  `CHK_NEXT(a_write_quiet, clk, rst, start && !busy && operation == OP_WRITE, !busy && !done)
  `CHK_IMPLY(a_done_after_busy, clk, rst, done, $past(busy))

endmodule

bind tile_box_collision_probe tbcp_checker u_tbcp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done)
);

### tb/tb_tile_box_collision_probe.sv
`timescale 1ns / 100ps

module tb_tile_box_collision_probe;
  import tbcp_pkg::*;

  localparam logic ORIENT_VERTICAL   = 1'b0;
  localparam logic ORIENT_HORIZONTAL = 1'b1;
  localparam int   SETTLE_CYCLES     = 12;

  typedef struct packed {
    logic              hit;
    logic [3:0]        sides;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } collision_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              operation = OP_TEST;
  logic [15:0]       box_left = '0;
  logic [15:0]       box_top = '0;
  logic [15:0]       box_right = '0;
  logic [15:0]       box_bottom = '0;
  logic [7:0]        bitmap_address = '0;
  logic [7:0]        bitmap_byte = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              done;
  logic              collided;
  logic [3:0]        side_flags;
  logic signed [7:0] push_x;
  logic signed [7:0] push_y;

  logic [7:0]  tile_map [256];
  logic        map_orient = ORIENT_VERTICAL;
  collision_t  collision_q [$];
  int          gap_limit = 10;
  int          n_errors = 0;
  int          n_tests = 0;
  int          n_writes = 0;
  int          n_hits = 0;
  int          n_one_sided = 0;
  int          n_cfg = 0;

  tile_box_collision_probe dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_right      (box_right),
    .box_bottom     (box_bottom),
    .bitmap_address (bitmap_address),
    .bitmap_byte    (bitmap_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .collided       (collided),
    .side_flags     (side_flags),
    .push_x         (push_x),
    .push_y         (push_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #4800000;
    $display("timeout with %0d results pending", collision_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic tile_solid(input logic [15:0] x, input logic [15:0] y);
    int unsigned ry;
    int unsigned row;
    int unsigned scr;
    logic        lower;
    logic [7:0]  addr;
    ry    = y % 240;
    lower = (ry >= 128);
    row   = lower ? ((ry - 128) >> 3) : (ry >> 3);
    scr   = (map_orient == ORIENT_HORIZONTAL) ? x[8] : ((y / 240) & 1);
    addr  = {scr[0], lower, x[7], row[3:0], x[6]};
    return tile_map[addr][x[5:3]];
  endfunction

  function automatic logic [7:0] axis_push(input logic [15:0] lo, input logic [15:0] hi,
                                           input logic hit_lo, input logic hit_hi);
    logic [7:0] lo8;
    logic [7:0] hi8;
    logic [7:0] span;
    logic [7:0] inner;
    lo8   = lo[7:0];
    hi8   = hi[7:0];
    span  = hi8 + 8'd1 - lo8;
    inner = hi8 - lo8;
    if (hit_lo && !hit_hi) return 8'd8 - {5'd0, lo8[2:0]};
    if (hit_hi && !hit_lo) return inner - {5'd0, hi8[2:0]};
    return {1'b0, span[7:1]};
  endfunction

  function automatic collision_t compute_collision(input logic [15:0] l, input logic [15:0] t,
                                                   input logic [15:0] r, input logic [15:0] b);
    logic [15:0] xr;
    logic [15:0] yb;
    logic [3:0]  f;
    collision_t  res;
    xr = r - 16'd1;
    yb = b - 16'd1;
    f  = '0;
    if (tile_solid(l, t))  f |= FLAG_LEFT | FLAG_UP;
    if (tile_solid(xr, t)) f |= FLAG_RIGHT | FLAG_UP;
    if (tile_solid(l, yb)) f |= FLAG_LEFT | FLAG_DOWN;
    if (tile_solid(xr, yb)) f |= FLAG_RIGHT | FLAG_DOWN;
    res.hit   = (f != 4'd0);
    res.sides = f;
    res.dx    = axis_push(l, xr, (f & FLAG_LEFT) != 0, (f & FLAG_RIGHT) != 0);
    res.dy    = axis_push(t, yb, (f & FLAG_UP) != 0, (f & FLAG_DOWN) != 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  always @(posedge clk) begin : check_results
    collision_t want;
    if (!rst && done) begin
      if (collision_q.size() == 0) begin
        report_mismatch("result with no request pending", collided, 0);
      end else begin
        want = collision_q.pop_front();
        if (collided !== want.hit) report_mismatch("collided", collided, want.hit);
        if (side_flags !== want.sides) report_mismatch("side_flags", side_flags, want.sides);
        if (push_x !== want.dx) report_mismatch("push_x", push_x, want.dx);
        if (push_y !== want.dy) report_mismatch("push_y", push_y, want.dy);
      end
    end
  end

  task automatic send_request(input logic op, input logic [15:0] l, input logic [15:0] t,
                              input logic [15:0] r, input logic [15:0] b,
                              input logic [7:0] addr, input logic [7:0] data);
    int         gap;
    collision_t want;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    operation      <= op;
    box_left       <= l;
    box_top        <= t;
    box_right      <= r;
    box_bottom     <= b;
    bitmap_address <= addr;
    bitmap_byte    <= data;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) begin
      tile_map[addr] = data;
      n_writes++;
    end else begin
      want = compute_collision(l, t, r, b);
      collision_q.push_back(want);
      n_tests++;
      if (want.hit) n_hits++;
      if (want.sides[0] != want.sides[1] || want.sides[2] != want.sides[3]) n_one_sided++;
    end
  endtask

  task automatic write_byte(input logic [7:0] addr, input logic [7:0] data);
    send_request(OP_WRITE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 addr, data);
  endtask

  task automatic test_box(input logic [15:0] l, input logic [15:0] t,
                          input logic [15:0] r, input logic [15:0] b);
    send_request(OP_TEST, l, t, r, b, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (collision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_orientation(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    map_orient = value;
    n_cfg++;
  endtask

  function automatic logic [15:0] box_edge(input logic [15:0] lo);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return lo + 16'($urandom_range(1, 40));
    if (sel < 18) return lo - 16'($urandom_range(0, 8));
    return 16'($urandom);
  endfunction

  task automatic run_random(input int count);
    logic [15:0] l;
    logic [15:0] t;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 10;
      if ($urandom_range(0, 99) == 0) wait_for_results();
      l = 16'($urandom);
      t = 16'($urandom);
      send_request(($urandom_range(0, 3) == 0) ? OP_WRITE : OP_TEST,
                   l, t, box_edge(l), box_edge(t), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_map_fill();
    for (int a = 0; a < 256; a++) write_byte(a[7:0], 8'($urandom));
  endtask

  task automatic test_corner_cases();
    gap_limit = 10;
    write_byte(8'd0, 8'hFF);
    write_byte(8'd1, 8'h00);
    write_byte(8'd2, 8'h00);
    write_byte(8'd3, 8'h00);
    test_box(16'd60, 16'd2, 16'd70, 16'd6);
    write_byte(8'd0, 8'h00);
    write_byte(8'd1, 8'hFF);
    test_box(16'd60, 16'd2, 16'd70, 16'd6);
    write_byte(8'd1, 8'h00);
    write_byte(8'd2, 8'hFF);
    test_box(16'd10, 16'd4, 16'd20, 16'd12);
    write_byte(8'd0, 8'hFF);
    write_byte(8'd2, 8'h00);
    test_box(16'd10, 16'd4, 16'd20, 16'd12);
    write_byte(8'd0, 8'h00);
    test_box(16'd10, 16'd4, 16'd20, 16'd12);
    test_box(16'd0, 16'd0, 16'd1, 16'd1);
    test_box(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    test_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    test_box(16'd100, 16'd100, 16'd100, 16'd100);
    test_box(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    test_box(16'd5, 16'd239, 16'd9, 16'd241);
  endtask

  task automatic test_vertical_screens();
    run_random(450);
  endtask

  task automatic test_horizontal_screens();
    wait_for_results();
    write_orientation(ORIENT_HORIZONTAL);
    run_random(550);
  endtask

  task automatic test_back_to_vertical();
    wait_for_results();
    write_orientation(ORIENT_VERTICAL);
    run_random(430);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_map_fill();
    test_corner_cases();
    test_vertical_screens();
    test_horizontal_screens();
    test_back_to_vertical();
    wait_for_results();
    $display("covered %0d box probes (%0d with hits, %0d pushed toward one side)",
             n_tests, n_hits, n_one_sided);
    $display("and %0d bitmap writes across %0d orientation changes", n_writes, n_cfg);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tbcp_pkg.sv
rtl/tile_box_collision_probe.sv
rtl/tbcp_checker.sv
tb/tb_tile_box_collision_probe.sv
